// File: rtl/llra_pkg.sv
// Package for the least-loaded row assigner.
// Holds field widths, register indexes, the chain token and control structs
// and the controller state type. No dependencies.
package llra_pkg;

   localparam int LOAD_W   = 16;
   localparam int GLYPH_W  = 12;
   localparam int PAD_W    = 9;
   localparam int RCNT_W   = 5;
   localparam int ROWOUT_W = 4;
   localparam int ROWCMP_W = 9;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

   localparam logic REG_ROW_COUNT = 1'b0;
   localparam logic REG_PAD       = 1'b1;

   typedef struct packed {
      logic [LOAD_W-1:0] min_load;
      logic [LOAD_W-1:0] max_load;
   } token_type;

   typedef struct packed {
      logic              fill;
      logic [LOAD_W-1:0] fill_value;
      logic              wr_en;
      logic [LOAD_W-1:0] wr_value;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

endpackage

// File: rtl/llra_cell.sv
// One row cell: holds a single row load and forwards the running minimum,
// maximum and winning row index to its neighbor each cycle.
// Depends on llra_pkg.
module llra_cell import llra_pkg::*; #(
   parameter int IDX_W = 4,
   parameter int ROW   = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               active,
   input  cell_ctl_type       ctl,
   input  logic [IDX_W-1:0]   wr_idx,
   input  token_type          tok_in,
   input  logic [IDX_W-1:0]   idx_in,
   output token_type          tok_out,
   output logic [IDX_W-1:0]   idx_out
);

   logic [LOAD_W-1:0] load_ff, load_in;
   token_type         tok_ff, tok_in_nxt;
   logic [IDX_W-1:0]  idx_ff, idx_in_nxt;
   logic              take_min;
   logic              take_max;

   always_comb begin
      take_min = active && (load_ff < tok_in.min_load);
      take_max = active && (load_ff > tok_in.max_load);
      tok_in_nxt.min_load = take_min ? load_ff : tok_in.min_load;
      tok_in_nxt.max_load = take_max ? load_ff : tok_in.max_load;
      idx_in_nxt = take_min ? IDX_W'(ROW) : idx_in;
      if (ctl.fill) begin
         load_in = ctl.fill_value;
      end else if (ctl.wr_en && (wr_idx == IDX_W'(ROW))) begin
         load_in = ctl.wr_value;
      end else begin
         load_in = load_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= '0;
      end else begin
         load_ff <= load_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in_nxt;
      idx_ff <= idx_in_nxt;
   end

   assign tok_out = tok_ff;
   assign idx_out = idx_ff;

endmodule

// File: rtl/llra_chain.sv
// Row of load cells from row 0 upward; the token enters at row 0 and
// leaves the last cell, registered once in each cell on the way.
// Depends on llra_pkg and llra_cell.
module llra_chain import llra_pkg::*; #(
   parameter int MAX_ROWS = 16,
   parameter int IDX_W    = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [RCNT_W-1:0]  row_count,
   input  cell_ctl_type       ctl,
   input  logic [IDX_W-1:0]   wr_idx,
   output token_type          tok_end,
   output logic [IDX_W-1:0]   idx_end
);

   token_type        tok [0:MAX_ROWS];
   logic [IDX_W-1:0] idx [0:MAX_ROWS];

   assign tok[0].min_load = LOAD_MAX;
   assign tok[0].max_load = '0;
   assign idx[0]          = '0;

   for (genvar k = 0; k < MAX_ROWS; k++) begin : g_cell
      logic active;
      assign active = (k == 0) ||
                      (ROWCMP_W'(k) < ROWCMP_W'(row_count));
      llra_cell #(
         .IDX_W (IDX_W),
         .ROW   (k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .active  (active),
         .ctl     (ctl),
         .wr_idx  (wr_idx),
         .tok_in  (tok[k]),
         .idx_in  (idx[k]),
         .tok_out (tok[k+1]),
         .idx_out (idx[k+1])
      );
   end

   assign tok_end = tok[MAX_ROWS];
   assign idx_end = idx[MAX_ROWS];

endmodule

// File: rtl/least_loaded_row_assigner.sv
// Least-loaded row assigner: top level with stream ports, register port
// and controller. Depends on llra_pkg and llra_chain.
//
// Usage: each req beat carries a glyph width (tdata) and a last-glyph flag
// (tlast). The block places the glyph on the active row with the smallest
// load, lowest index on ties, and returns one rsp beat with the row index.
// On a last glyph the rsp beat also carries the largest row load and every
// load goes back to the padding value for the next pass.
// rsp_tvalid rises once the token has travelled through the cell chain,
// registered once in each cell. A new glyph is accepted only after the last
// has finished its scan; req_tready is high only while no glyph is in the chain.
// The result sits in an output register; a new glyph is accepted while it
// waits. When the receiver stalls, a finished scan holds until that register
// is free. Register writes (row_count at 0x0, pad_pixels at 0x4) reload all
// row loads with the padding value and are to be made by the user only while
// the block is idle; the block itself does not enforce this.
// Reset sets row_count to 1, pad_pixels to 0 and all loads to 0.
module least_loaded_row_assigner import llra_pkg::*; #(
   parameter int MAX_ROWS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [15:0]        req_tdata,   // [11:0] glyph_width
   input  logic               req_tlast,   // is_last
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [23:0]        rsp_tdata,   // [3:0] row_index, [19:4] max_row_width
   output logic               rsp_tlast,   // final_res
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [ADDR_W-1:0]  csr_paddr,
   input  logic [DATA_W-1:0]  csr_pwdata,
   output logic [DATA_W-1:0]  csr_prdata,
   output logic               csr_pready
);

   localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic [RCNT_W-1:0]  row_count_ff, row_count_in;
   logic [PAD_W-1:0]   pad_ff, pad_in;
   logic [GLYPH_W-1:0] width_ff, width_in;
   logic               last_ff, last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ROWOUT_W-1:0] rsp_row_ff, rsp_row_in;
   logic [LOAD_W-1:0]  rsp_max_ff, rsp_max_in;
   logic               rsp_final_ff, rsp_final_in;

   logic               accept;
   logic               cfg_wr;
   logic               finish;
   logic [LOAD_W:0]    sum_wide;
   logic [LOAD_W-1:0]  sum_sat;
   logic [LOAD_W-1:0]  peak;
   logic [IDX_W+ROWOUT_W-1:0] idx_ext;
   cell_ctl_type       ctl;
   token_type          tok_end;
   logic [IDX_W-1:0]   idx_end;

   assign accept = req_tvalid && req_tready;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign finish = (state_ff == ST_SCAN) && (cnt_ff == IDX_W'(MAX_ROWS - 1)) &&
                   (!rsp_valid_ff || rsp_tready);

   always_comb begin
      sum_wide = {1'b0, tok_end.min_load} + (LOAD_W + 1)'(width_ff) +
                 (LOAD_W + 1)'(pad_ff);
      sum_sat  = sum_wide[LOAD_W] ? LOAD_MAX : sum_wide[LOAD_W-1:0];
      peak     = (tok_end.max_load > sum_sat) ? tok_end.max_load : sum_sat;
      idx_ext  = {{ROWOUT_W{1'b0}}, idx_end};
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      width_in     = width_ff;
      last_in      = last_ff;
      row_count_in = row_count_ff;
      pad_in       = pad_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_final_in = rsp_final_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ctl.fill       = 1'b0;
      ctl.fill_value = LOAD_W'(pad_ff);
      ctl.wr_en      = 1'b0;
      ctl.wr_value   = sum_sat;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               width_in = req_tdata[GLYPH_W-1:0];
               last_in  = req_tlast;
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (finish) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = idx_ext[ROWOUT_W-1:0];
               rsp_max_in   = last_ff ? peak : '0;
               rsp_final_in = last_ff;
               ctl.fill     = last_ff;
               ctl.wr_en    = !last_ff;
               state_in     = ST_IDLE;
            end else if (cnt_ff != IDX_W'(MAX_ROWS - 1)) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg_wr) begin
         ctl.fill = 1'b1;
         if (csr_paddr[2] == REG_ROW_COUNT) begin
            row_count_in = csr_pwdata[RCNT_W-1:0];
         end else begin
            pad_in         = csr_pwdata[PAD_W-1:0];
            ctl.fill_value = LOAD_W'(csr_pwdata[PAD_W-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         row_count_ff <= RCNT_W'(1);
         pad_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         row_count_ff <= row_count_in;
         pad_ff       <= pad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff     <= width_in;
      last_ff      <= last_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_max_ff   <= rsp_max_in;
      rsp_final_ff <= rsp_final_in;
   end

   llra_chain #(
      .MAX_ROWS (MAX_ROWS),
      .IDX_W    (IDX_W)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .row_count (row_count_ff),
      .ctl       (ctl),
      .wr_idx    (idx_end),
      .tok_end   (tok_end),
      .idx_end   (idx_end)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_max_ff, rsp_row_ff};
   assign rsp_tlast  = rsp_final_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_ROW_COUNT) ? DATA_W'(row_count_ff) :
                                                         DATA_W'(pad_ff);

endmodule

// File: test/tb_top.sv
// Self-checking testbench for least_loaded_row_assigner: glyph beats in, row beats out.
// It predicts each row choice and pass maximum from its own row-load model and compares
// every rsp beat. Depends on llra_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
   import llra_pkg::*;

   localparam int MAX_ROWS  = 16;
   localparam int LONG_HOLD = 300;

   typedef struct {
      logic [GLYPH_W-1:0] width;
      logic               last;
   } glyph_beat_type;

   typedef struct packed {
      logic [ROWOUT_W-1:0] row;
      logic [LOAD_W-1:0]   peak;
      logic                fin;
   } row_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [15:0]       req_tdata = '0;
   logic              req_tlast = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [23:0]       rsp_tdata;
   logic              rsp_tlast;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [DATA_W-1:0] csr_pwdata = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   glyph_beat_type glyph_queue[$];
   row_result_type row_expect[$];
   glyph_beat_type req_beat;
   int          idle_pct = 30;
   int          long_holds_wanted = 0;
   int          fail_count = 0;

   logic [RCNT_W-1:0] model_rows;
   logic [PAD_W-1:0]  model_pad;
   logic [LOAD_W-1:0] model_load [MAX_ROWS];

   least_loaded_row_assigner #(.MAX_ROWS(MAX_ROWS)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   function automatic void refill_loads();
      for (int k = 0; k < MAX_ROWS; k++) model_load[k] = LOAD_W'(model_pad);
   endfunction

   function automatic row_result_type place_glyph(logic [GLYPH_W-1:0] width, logic last);
      int          n;
      int          best;
      int          sum;
      logic [LOAD_W-1:0] peak;
      row_result_type res;
      n = model_rows;
      if (n < 1) n = 1;
      if (n > MAX_ROWS) n = MAX_ROWS;
      best = 0;
      for (int k = 1; k < n; k++)
         if (model_load[k] < model_load[best]) best = k;
      sum = int'(model_load[best]) + int'(width) + int'(model_pad);
      if (sum > int'(LOAD_MAX)) sum = int'(LOAD_MAX);
      model_load[best] = LOAD_W'(sum);
      peak = '0;
      if (last) begin
         for (int k = 0; k < n; k++)
            if (model_load[k] > peak) peak = model_load[k];
         refill_loads();
      end
      res.row  = ROWOUT_W'(best);
      res.peak = peak;
      res.fin  = last;
      return res;
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

   always @(posedge clock) begin : drive_req
      int req_gap;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            row_expect.insert(row_expect.size(), place_glyph(req_beat.width, req_beat.last));
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (glyph_queue.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
               req_gap = $urandom_range(1, 12) - 1;
               req_tvalid <= 1'b0;
            end else begin
               req_beat = glyph_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {4'b0000, req_beat.width};
               req_tlast <= req_beat.last;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      int          rsp_gap;
      int          hold_left;
      int          holds_served;
      row_result_type want;
      logic [23:0] want_word;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap = 0;
         hold_left = 0;
         holds_served = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (row_expect.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected rsp beat: tdata %h tlast %b", rsp_tdata, rsp_tlast);
            end else begin
               want = row_expect.pop_front();
               want_word = {4'b0000, want.peak, want.row};
               if (rsp_tdata !== want_word || rsp_tlast !== want.fin) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("rsp mismatch: row %0d (exp %0d) max %0d (exp %0d) last %b (exp %b)",
                              rsp_tdata[3:0], want.row, rsp_tdata[19:4], want.peak,
                              rsp_tlast, want.fin);
               end
            end
         end
         if (holds_served != long_holds_wanted) begin
            holds_served = long_holds_wanted;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            rsp_gap = $urandom_range(1, 12) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic wait_drained();
      while (glyph_queue.size() != 0 || req_tvalid || row_expect.size() != 0)
         @(posedge clock);
      repeat (MAX_ROWS + 4) @(posedge clock);
   endtask

   task automatic write_csr(logic index, int value);
      logic [DATA_W-1:0] data;
      data = $urandom_range(1) ? DATA_W'($urandom) : '0;
      if (index == REG_ROW_COUNT) data[RCNT_W-1:0] = RCNT_W'(value);
      else data[PAD_W-1:0] = PAD_W'(value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (index == REG_ROW_COUNT) model_rows = data[RCNT_W-1:0];
      else model_pad = data[PAD_W-1:0];
      refill_loads();
   endtask

   task automatic push_glyph(int width, logic last);
      glyph_beat_type b;
      b.width = GLYPH_W'(width);
      b.last = last;
      glyph_queue.insert(glyph_queue.size(), b);
   endtask

   task automatic run_random_phase(int n_items, int rows, int pad, int idle, bit hold);
      int left;
      int len;
      int mode;
      int w;
      wait_drained();
      idle_pct = idle;
      if ($urandom_range(1)) begin
         write_csr(REG_ROW_COUNT, rows);
         write_csr(REG_PAD, pad);
      end else begin
         write_csr(REG_PAD, pad);
         write_csr(REG_ROW_COUNT, rows);
      end
      if (hold) long_holds_wanted <= long_holds_wanted + 1;
      left = n_items;
      while (left > 0) begin
         if ($urandom_range(9) == 0) len = $urandom_range(20, 40);
         else len = $urandom_range(1, 2 * rows + 3);
         mode = $urandom_range(2);
         for (int k = 0; k < len && left > 0; k++) begin
            case (mode)
               0: begin
                  w = $urandom_range(4095);
               end
               1: begin
                  w = $urandom_range(3500, 4095);
               end
               default: begin
                  w = $urandom_range(3);
               end
            endcase
            push_glyph(w, (k == len - 1) || ($urandom_range(31) == 0));
            left--;
         end
      end
   endtask

   initial begin : main
      int rows;
      int pad;
      int idle;
      model_rows = RCNT_W'(1);
      model_pad = '0;
      refill_loads();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      push_glyph(4095, 1'b0);
      push_glyph(0, 1'b1);

      wait_drained();
      write_csr(REG_ROW_COUNT, 31);
      write_csr(REG_PAD, 1);
      push_glyph(10, 1'b0);
      push_glyph(5, 1'b0);
      push_glyph(0, 1'b0);
      push_glyph(4095, 1'b0);
      push_glyph(7, 1'b1);

      wait_drained();
      write_csr(REG_ROW_COUNT, 0);
      write_csr(REG_PAD, 511);
      for (int k = 0; k < 15; k++) push_glyph(4095, k == 14);

      for (int p = 0; p < 12; p++) begin
         case (p)
            0: rows = 1;
            1: rows = 16;
            2: rows = 0;
            3: rows = 31;
            4: rows = 2;
            default: rows = $urandom_range(0, 31);
         endcase
         case (p % 3)
            0: pad = 0;
            1: pad = 511;
            default: pad = $urandom_range(511);
         endcase
         if (p == 11) idle = 0;
         else if (p % 4 == 2) idle = 0;
         else idle = $urandom_range(1) ? 20 : 50;
         run_random_phase(56, rows, pad, idle, p == 3);
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && row_expect.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
